FILE: hw/rtl/phpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phpi_pkg
// shared types, constants and fixed-point helpers of the periodic hermite
// parameter interpolator
// ----------------------------------------------------------------------------
package phpi_pkg;

  localparam int MAX_CHANNELS      = 8;
  localparam int KNOTS_PER_CHANNEL = 16;
  localparam int CH_W        = $clog2(MAX_CHANNELS);
  localparam int SLOT_W      = $clog2(KNOTS_PER_CHANNEL);
  localparam int ADDR_W      = CH_W + SLOT_W;
  localparam int STORE_DEPTH = MAX_CHANNELS * KNOTS_PER_CHANNEL;
  localparam int CNT_W       = $clog2(KNOTS_PER_CHANNEL + 1);
  localparam int ACT_W       = $clog2(MAX_CHANNELS + 1);

  // internal q34.16 word, holds +-(2^47-1) plus the raw differences
  localparam int QW    = 50;
  localparam int DVD_W = QW + 16;
  typedef logic signed [QW-1:0] q_t;
  localparam q_t QLIM    = q_t'(64'sh7FFF_FFFF_FFFF);
  localparam q_t Q_ONE   = q_t'(64'sd65536);
  localparam q_t I32_MAX = q_t'(64'sd2147483647);
  localparam q_t I32_MIN = q_t'(-64'sd2147483648);

  typedef struct packed {
    logic              operation;
    logic [2:0]        channel;
    logic [3:0]        knot_slot;
    logic [4:0]        knot_total;
    logic [31:0]       knot_time;
    logic signed [31:0] knot_value;
    logic [31:0]       query_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic signed [31:0] interpolated;
    logic               saturated;
    logic               last_of_query;
  } out_item_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CH, S_CHK, S_EMIT1, S_PER, S_SRCH, S_IDX, S_FETCH,
    S_DIFF, S_GO, S_WAIT, S_BAS, S_EMIT, S_NEXT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_QINIT, CMD_CH, CMD_RD0, CMD_RDPER, CMD_SRCH0,
    CMD_SRCH, CMD_IDX, CMD_FETCH, CMD_DIFF, CMD_GO, CMD_BAS, CMD_EMIT1,
    CMD_EMIT, CMD_NEXT
  } cmd_t;

  typedef enum logic [3:0] {
    AOP_X, AOP_M1, AOP_M2, AOP_X2, AOP_X3,
    AOP_P0, AOP_P1, AOP_P2, AOP_P3, AOP_P4, AOP_P5
  } aop_t;

  typedef struct packed {
    cmd_t       cmd;
    aop_t       aop;
    logic [1:0] bstep;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_le1;
    logic srch_done;
    logic fetch_done;
    logic unit_done;
    logic last_ch;
  } dp_status_t;

  function automatic logic q_clip(logic signed [QW:0] v);
    return (v > QLIM) || (v < -QLIM);
  endfunction

  function automatic q_t q_sat(logic signed [QW:0] v);
    if (v > QLIM) return QLIM;
    if (v < -QLIM) return -QLIM;
    return v[QW-1:0];
  endfunction

  function automatic logic signed [QW:0] q_sum(q_t a, q_t b);
    return {a[QW-1], a} + {b[QW-1], b};
  endfunction

endpackage

FILE: hw/rtl/phpi_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phpi_muldiv
// bit-serial q34.16 multiply / divide unit with saturation
// ----------------------------------------------------------------------------
module phpi_muldiv (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic           is_div,
  input  phpi_pkg::q_t   a,
  input  phpi_pkg::q_t   b,
  output logic           done,
  output phpi_pkg::q_t   r,
  output logic           ovf
);

  localparam int QW    = phpi_pkg::QW;
  localparam int DW    = phpi_pkg::DVD_W;
  localparam int CW    = $clog2(DW + 1);

  logic          running;
  logic          div_mode;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [QW-1:0] ua;
  logic [QW-1:0] ub;
  logic [QW-1:0] hi;
  logic [QW-1:0] lo;
  logic [DW-1:0] dvd;
  logic [QW-1:0] rem;

  logic [QW:0]     msum;
  logic [QW:0]     rem_sh;
  logic            ge;
  logic [CW-1:0]   steps;
  logic [2*QW-1:0] prod;
  logic [QW-1:0]   mag;
  logic            mag_ovf;

  always_comb begin
    msum   = {1'b0, hi} + (lo[0] ? {1'b0, ua} : {(QW+1){1'b0}});
    rem_sh = {rem, dvd[DW-1]};
    ge     = rem_sh >= {1'b0, ub};
    steps  = div_mode ? CW'(DW) : CW'(QW);
    prod   = {hi, lo};
    mag     = '0;
    mag_ovf = 1'b0;
    if (div_mode) begin
      if (ub == '0) begin
        mag_ovf = 1'b1;
      end else if (dvd > DW'(phpi_pkg::QLIM)) begin
        mag     = phpi_pkg::QLIM;
        mag_ovf = 1'b1;
      end else begin
        mag = dvd[QW-1:0];
      end
    end else begin
      if (prod > ((2*QW)'(phpi_pkg::QLIM) << 16)) begin
        mag     = phpi_pkg::QLIM;
        mag_ovf = 1'b1;
      end else begin
        mag = prod[QW+15:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running  <= 1'b1;
        cnt      <= '0;
        div_mode <= is_div;
        neg      <= a[QW-1] ^ b[QW-1];
        ua       <= a[QW-1] ? QW'(-a) : QW'(a);
        ub       <= b[QW-1] ? QW'(-b) : QW'(b);
        hi       <= '0;
        lo       <= b[QW-1] ? QW'(-b) : QW'(b);
        dvd      <= {(a[QW-1] ? QW'(-a) : QW'(a)), 16'h0000};
        rem      <= '0;
      end else if (running) begin
        if (cnt == steps) begin
          running <= 1'b0;
          done    <= 1'b1;
          r       <= neg ? -$signed(mag) : $signed(mag);
          ovf     <= mag_ovf;
        end else begin
          cnt <= cnt + CW'(1);
          if (div_mode) begin
            rem <= ge ? QW'(rem_sh - {1'b0, ub}) : rem_sh[QW-1:0];
            dvd <= {dvd[DW-2:0], ge};
          end else begin
            hi <= msum[QW:1];
            lo <= {msum[0], lo[QW-1:1]};
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/phpi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phpi_dp
// datapath: knot stores, segment search, hermite arithmetic, result register
// ----------------------------------------------------------------------------
module phpi_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  phpi_pkg::in_item_t    item,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_data,
  input  phpi_pkg::ctrl_cmd_t   ctl,
  output phpi_pkg::dp_status_t  st,
  output logic                  done,
  output phpi_pkg::out_item_t   result
);

  localparam int QW     = phpi_pkg::QW;
  localparam int CH_W   = phpi_pkg::CH_W;
  localparam int SLOT_W = phpi_pkg::SLOT_W;
  localparam int ADDR_W = phpi_pkg::ADDR_W;
  localparam int CNT_W  = phpi_pkg::CNT_W;
  localparam int ACT_W  = phpi_pkg::ACT_W;
  localparam int KN     = phpi_pkg::KNOTS_PER_CHANNEL;
  localparam int MC     = phpi_pkg::MAX_CHANNELS;

  logic [31:0] tmem [phpi_pkg::STORE_DEPTH];
  logic [31:0] vmem [phpi_pkg::STORE_DEPTH];
  logic [CNT_W-1:0] count_store [MC];

  logic [3:0]        active_channels;
  logic [ACT_W-1:0]  act;
  logic [CH_W-1:0]   k;
  logic [31:0]       qt;
  logic [CNT_W-1:0]  n;
  logic [31:0]       rd_t;
  logic [31:0]       rd_v;
  logic [31:0]       prev_t;
  logic [CNT_W-1:0]  j;
  logic              found;
  logic [SLOT_W-1:0] seg;
  logic [SLOT_W-1:0] jsel [4];
  logic              sh0;
  logic              sh3;
  logic [2:0]        fc;
  phpi_pkg::q_t      per;
  phpi_pkg::q_t      kt [4];
  phpi_pkg::q_t      kv [4];
  phpi_pkg::q_t      h, dx, dv2, dt2, dv3, dt3;
  phpi_pkg::q_t      x, x2, x3, m1, m2, tmp, res;
  phpi_pkg::q_t      a2, c2, c3, t10, b00, b10, b01, b11;
  logic              flag;

  logic [ADDR_W-1:0] raddr;
  logic [CNT_W-1:0]  total_clamped;
  logic              hit;
  phpi_pkg::q_t      ua, ub;
  logic              u_div;
  logic              u_done;
  phpi_pkg::q_t      u_r;
  logic              u_ovf;
  phpi_pkg::q_t      cap_t;
  phpi_pkg::q_t      cap_v;

  phpi_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .go     (ctl.cmd == phpi_pkg::CMD_GO),
    .is_div (u_div),
    .a      (ua),
    .b      (ub),
    .done   (u_done),
    .r      (u_r),
    .ovf    (u_ovf)
  );

  always_comb begin
    if (item.knot_total == 5'd0) total_clamped = CNT_W'(1);
    else if (32'(item.knot_total) > KN) total_clamped = CNT_W'(KN);
    else total_clamped = CNT_W'(item.knot_total);

    hit = (j != '0) && (qt >= prev_t) && (qt < rd_t);

    raddr = '0;
    unique case (ctl.cmd)
      phpi_pkg::CMD_RD0:   raddr = {k, SLOT_W'(0)};
      phpi_pkg::CMD_RDPER: raddr = {k, SLOT_W'(n - CNT_W'(1))};
      phpi_pkg::CMD_SRCH0: raddr = {k, SLOT_W'(0)};
      phpi_pkg::CMD_SRCH:  raddr = {k, SLOT_W'(j + CNT_W'(1))};
      phpi_pkg::CMD_FETCH: raddr = {k, jsel[fc[1:0]]};
      default:             raddr = '0;
    endcase

    cap_t = phpi_pkg::q_t'({{(QW-32){1'b0}}, rd_t});
    cap_v = phpi_pkg::q_t'({{(QW-32){rd_v[31]}}, rd_v});
    if (fc == 3'd1 && sh0) cap_t = cap_t - per;
    if (fc == 3'd4 && sh3) cap_t = cap_t + per;

    u_div = 1'b0;
    ua    = tmp;
    ub    = m2;
    case (ctl.aop)
      phpi_pkg::AOP_X:  begin u_div = 1'b1; ua = dx;  ub = h;   end
      phpi_pkg::AOP_M1: begin u_div = 1'b1; ua = dv2; ub = dt2; end
      phpi_pkg::AOP_M2: begin u_div = 1'b1; ua = dv3; ub = dt3; end
      phpi_pkg::AOP_X2: begin ua = x;   ub = x;     end
      phpi_pkg::AOP_X3: begin ua = x2;  ub = x;     end
      phpi_pkg::AOP_P0: begin ua = b00; ub = kv[1]; end
      phpi_pkg::AOP_P1: begin ua = b10; ub = h;     end
      phpi_pkg::AOP_P2: begin ua = tmp; ub = m1;    end
      phpi_pkg::AOP_P3: begin ua = b01; ub = kv[2]; end
      phpi_pkg::AOP_P4: begin ua = b11; ub = h;     end
      default:          begin ua = tmp; ub = m2;    end
    endcase

    st.n_le1      = n <= CNT_W'(1);
    st.srch_done  = hit || (j == n - CNT_W'(1));
    st.fetch_done = fc == 3'd4;
    st.unit_done  = u_done;
    st.last_ch    = (ACT_W'(k) + ACT_W'(1)) == act;
  end

  // knot stores, registered read
  always_ff @(posedge clk) begin
    if (ctl.cmd == phpi_pkg::CMD_LOAD && 32'(item.channel) < MC &&
        32'(item.knot_slot) < KN) begin
      tmem[{item.channel[CH_W-1:0], item.knot_slot[SLOT_W-1:0]}] <= item.knot_time;
      vmem[{item.channel[CH_W-1:0], item.knot_slot[SLOT_W-1:0]}] <= item.knot_value;
    end
    rd_t <= tmem[raddr];
    rd_v <= vmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= 4'd1;
      for (int c = 0; c < MC; c++) count_store[c] <= CNT_W'(1);
      done <= 1'b0;
      k    <= '0;
      act  <= ACT_W'(1);
    end else begin
      done <= 1'b0;
      if (cfg_we) active_channels <= cfg_data;
      if (ctl.cmd == phpi_pkg::CMD_LOAD && 32'(item.channel) < MC &&
          32'(item.knot_slot) < KN)
        count_store[item.channel[CH_W-1:0]] <= total_clamped;
      if (ctl.cmd == phpi_pkg::CMD_QINIT) begin
        k  <= '0;
        qt <= item.query_time;
        if (active_channels == 4'd0) act <= ACT_W'(1);
        else if (32'(active_channels) > MC) act <= ACT_W'(MC);
        else act <= ACT_W'(active_channels);
      end
      if (ctl.cmd == phpi_pkg::CMD_NEXT) k <= k + CH_W'(1);
      if (ctl.cmd == phpi_pkg::CMD_EMIT1 || ctl.cmd == phpi_pkg::CMD_EMIT) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      phpi_pkg::CMD_CH: begin
        n    <= count_store[k];
        flag <= 1'b0;
      end
      phpi_pkg::CMD_SRCH0: begin
        per   <= phpi_pkg::q_t'({{(QW-32){1'b0}}, rd_t});
        j     <= '0;
        found <= 1'b0;
      end
      phpi_pkg::CMD_SRCH: begin
        prev_t <= rd_t;
        j      <= j + CNT_W'(1);
        if (hit) begin
          found <= 1'b1;
          seg   <= SLOT_W'(j - CNT_W'(1));
        end
      end
      phpi_pkg::CMD_IDX: begin
        fc <= '0;
        if (found) begin
          jsel[0] <= (seg == '0) ? SLOT_W'(n - CNT_W'(1)) : seg - SLOT_W'(1);
          jsel[1] <= seg;
          jsel[2] <= seg + SLOT_W'(1);
          jsel[3] <= (CNT_W'(seg) == n - CNT_W'(2)) ? SLOT_W'(0) : seg + SLOT_W'(2);
          sh0     <= seg == '0;
          sh3     <= CNT_W'(seg) == n - CNT_W'(2);
        end else begin
          jsel[0] <= SLOT_W'(n - CNT_W'(2));
          jsel[1] <= SLOT_W'(n - CNT_W'(1));
          jsel[2] <= SLOT_W'(0);
          jsel[3] <= SLOT_W'(1);
          sh0     <= 1'b0;
          sh3     <= 1'b0;
        end
      end
      phpi_pkg::CMD_FETCH: begin
        fc <= fc + 3'd1;
        if (fc != 3'd0) begin
          kt[fc[1:0] - 2'd1] <= cap_t;
          kv[fc[1:0] - 2'd1] <= cap_v;
        end
      end
      phpi_pkg::CMD_DIFF: begin
        h   <= kt[2] - kt[1];
        dx  <= phpi_pkg::q_t'({{(QW-32){1'b0}}, qt}) - kt[1];
        dv2 <= kv[2] - kv[0];
        dt2 <= kt[2] - kt[0];
        dv3 <= kv[3] - kv[1];
        dt3 <= kt[3] - kt[1];
      end
      phpi_pkg::CMD_BAS: begin
        case (ctl.bstep)
          2'd0: begin
            a2   <= phpi_pkg::q_sat(phpi_pkg::q_sum(x3, x3));
            c2   <= phpi_pkg::q_sat(phpi_pkg::q_sum(x2, x2));
            flag <= flag | phpi_pkg::q_clip(phpi_pkg::q_sum(x3, x3))
                         | phpi_pkg::q_clip(phpi_pkg::q_sum(x2, x2));
          end
          2'd1: begin
            c3   <= phpi_pkg::q_sat(phpi_pkg::q_sum(c2, x2));
            t10  <= phpi_pkg::q_sat(phpi_pkg::q_sum(x3, -c2));
            b11  <= phpi_pkg::q_sat(phpi_pkg::q_sum(x3, -x2));
            flag <= flag | phpi_pkg::q_clip(phpi_pkg::q_sum(c2, x2))
                         | phpi_pkg::q_clip(phpi_pkg::q_sum(x3, -c2))
                         | phpi_pkg::q_clip(phpi_pkg::q_sum(x3, -x2));
          end
          2'd2: begin
            b00  <= phpi_pkg::q_sat(phpi_pkg::q_sum(a2, -c3));
            b10  <= phpi_pkg::q_sat(phpi_pkg::q_sum(t10, x));
            b01  <= phpi_pkg::q_sat(phpi_pkg::q_sum(c3, -a2));
            flag <= flag | phpi_pkg::q_clip(phpi_pkg::q_sum(a2, -c3))
                         | phpi_pkg::q_clip(phpi_pkg::q_sum(t10, x))
                         | phpi_pkg::q_clip(phpi_pkg::q_sum(c3, -a2));
          end
          default: begin
            b00  <= phpi_pkg::q_sat(phpi_pkg::q_sum(b00, phpi_pkg::Q_ONE));
            flag <= flag | phpi_pkg::q_clip(phpi_pkg::q_sum(b00, phpi_pkg::Q_ONE));
          end
        endcase
      end
      phpi_pkg::CMD_EMIT1: begin
        result.out_channel   <= 3'(k);
        result.interpolated  <= rd_v;
        result.saturated     <= 1'b0;
        result.last_of_query <= st.last_ch;
      end
      phpi_pkg::CMD_EMIT: begin
        result.out_channel   <= 3'(k);
        result.last_of_query <= st.last_ch;
        if (res > phpi_pkg::I32_MAX) begin
          result.interpolated <= 32'sh7FFF_FFFF;
          result.saturated    <= 1'b1;
        end else if (res < phpi_pkg::I32_MIN) begin
          result.interpolated <= 32'sh8000_0000;
          result.saturated    <= 1'b1;
        end else begin
          result.interpolated <= res[31:0];
          result.saturated    <= flag;
        end
      end
      default: begin
      end
    endcase

    // unit write-back, the controller holds the op code until done
    if (u_done) begin
      case (ctl.aop) inside
        phpi_pkg::AOP_X:  x  <= u_r;
        phpi_pkg::AOP_M1: m1 <= u_r;
        phpi_pkg::AOP_M2: m2 <= u_r;
        phpi_pkg::AOP_X2: x2 <= u_r;
        phpi_pkg::AOP_X3: x3 <= u_r;
        phpi_pkg::AOP_P0: res <= u_r;
        phpi_pkg::AOP_P1, phpi_pkg::AOP_P4: tmp <= u_r;
        default: res <= phpi_pkg::q_sat(phpi_pkg::q_sum(res, u_r));
      endcase
      if (ctl.aop inside {phpi_pkg::AOP_P2, phpi_pkg::AOP_P3, phpi_pkg::AOP_P5})
        flag <= flag | u_ovf | phpi_pkg::q_clip(phpi_pkg::q_sum(res, u_r));
      else
        flag <= flag | u_ovf;
    end
  end

endmodule

FILE: hw/rtl/phpi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phpi_ctrl
// sequencer: load, per-channel search, fetch, arithmetic program, emit
// ----------------------------------------------------------------------------
module phpi_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  operation,
  input  phpi_pkg::dp_status_t  st,
  output phpi_pkg::ctrl_cmd_t   ctl,
  output logic                  busy
);

  phpi_pkg::ctrl_state_t state, state_next;
  phpi_pkg::aop_t        aop, aop_next;
  logic [1:0]            bstep, bstep_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= phpi_pkg::S_IDLE;
      aop   <= phpi_pkg::AOP_X;
      bstep <= 2'd0;
    end else begin
      state <= state_next;
      aop   <= aop_next;
      bstep <= bstep_next;
    end
  end

  always_comb begin
    state_next = state;
    aop_next   = aop;
    bstep_next = bstep;
    ctl.cmd    = phpi_pkg::CMD_NONE;
    ctl.aop    = aop;
    ctl.bstep  = bstep;
    busy       = state != phpi_pkg::S_IDLE;
    unique case (state)
      phpi_pkg::S_IDLE: begin
        if (start) begin
          if (operation == phpi_pkg::OP_LOAD) begin
            ctl.cmd = phpi_pkg::CMD_LOAD;
          end else begin
            ctl.cmd    = phpi_pkg::CMD_QINIT;
            state_next = phpi_pkg::S_CH;
          end
        end
      end
      phpi_pkg::S_CH: begin
        ctl.cmd    = phpi_pkg::CMD_CH;
        state_next = phpi_pkg::S_CHK;
      end
      phpi_pkg::S_CHK: begin
        if (st.n_le1) begin
          ctl.cmd    = phpi_pkg::CMD_RD0;
          state_next = phpi_pkg::S_EMIT1;
        end else begin
          ctl.cmd    = phpi_pkg::CMD_RDPER;
          state_next = phpi_pkg::S_PER;
        end
      end
      phpi_pkg::S_EMIT1: begin
        ctl.cmd    = phpi_pkg::CMD_EMIT1;
        state_next = phpi_pkg::S_NEXT;
      end
      phpi_pkg::S_PER: begin
        ctl.cmd    = phpi_pkg::CMD_SRCH0;
        state_next = phpi_pkg::S_SRCH;
      end
      phpi_pkg::S_SRCH: begin
        ctl.cmd = phpi_pkg::CMD_SRCH;
        if (st.srch_done) state_next = phpi_pkg::S_IDX;
      end
      phpi_pkg::S_IDX: begin
        ctl.cmd    = phpi_pkg::CMD_IDX;
        state_next = phpi_pkg::S_FETCH;
      end
      phpi_pkg::S_FETCH: begin
        ctl.cmd = phpi_pkg::CMD_FETCH;
        if (st.fetch_done) state_next = phpi_pkg::S_DIFF;
      end
      phpi_pkg::S_DIFF: begin
        ctl.cmd    = phpi_pkg::CMD_DIFF;
        aop_next   = phpi_pkg::AOP_X;
        state_next = phpi_pkg::S_GO;
      end
      phpi_pkg::S_GO: begin
        ctl.cmd    = phpi_pkg::CMD_GO;
        state_next = phpi_pkg::S_WAIT;
      end
      phpi_pkg::S_WAIT: begin
        if (st.unit_done) begin
          if (aop == phpi_pkg::AOP_X3) begin
            bstep_next = 2'd0;
            state_next = phpi_pkg::S_BAS;
          end else if (aop == phpi_pkg::AOP_P5) begin
            state_next = phpi_pkg::S_EMIT;
          end else begin
            aop_next   = phpi_pkg::aop_t'(aop + 4'd1);
            state_next = phpi_pkg::S_GO;
          end
        end
      end
      phpi_pkg::S_BAS: begin
        ctl.cmd    = phpi_pkg::CMD_BAS;
        bstep_next = bstep + 2'd1;
        if (bstep == 2'd3) begin
          aop_next   = phpi_pkg::AOP_P0;
          state_next = phpi_pkg::S_GO;
        end
      end
      phpi_pkg::S_EMIT: begin
        ctl.cmd    = phpi_pkg::CMD_EMIT;
        state_next = phpi_pkg::S_NEXT;
      end
      phpi_pkg::S_NEXT: begin
        if (st.last_ch) begin
          state_next = phpi_pkg::S_IDLE;
        end else begin
          ctl.cmd    = phpi_pkg::CMD_NEXT;
          state_next = phpi_pkg::S_CH;
        end
      end
      default: state_next = phpi_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/periodic_hermite_param_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_hermite_param_interpolator
// periodic cubic hermite interpolation of up to eight q16.16 parameter
// channels from stored knots
// ----------------------------------------------------------------------------
// usage
// - input beat: start high while busy is low; item.operation selects a knot
//   load (time, value and knot count of one channel) or a query at query_time
// - a load is written straight from idle, busy stays low, no result
// - a query gives one result beat per active channel, channel 0 first, each
//   on result for exactly one cycle with done high; the final one carries
//   last_of_query; the receiver cannot stall, so every beat must be taken
// - one-knot channels emit their stored knot value; other channels run a
//   segment search through the single knot memory port, then the bit-serial
//   multiply/divide unit (three 66-step divides, eight 50-step multiplies)
// - cfg_we writes active_channels (clamped to 1..8 at query start); the user
//   must write it only while no query is running, the block does not check
// - reset: active_channels = 1, each channel has one knot; knot memories
//   hold no defined contents until loaded
// ----------------------------------------------------------------------------
module periodic_hermite_param_interpolator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  phpi_pkg::in_item_t   item,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_data,
  output logic                 done,
  output phpi_pkg::out_item_t  result
);

  // command / status between sequencer and datapath
  phpi_pkg::ctrl_cmd_t  ctl;
  phpi_pkg::dp_status_t st;

  phpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (item.operation),
    .st        (st),
    .ctl       (ctl),
    .busy      (busy)
  );

  phpi_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .st       (st),
    .done     (done),
    .result   (result)
  );

  // a result beat only ever follows query work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without query in progress");

  // result beats never come back to back
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beats back to back");

  // a load beat leaves the block idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.operation == phpi_pkg::OP_LOAD) |=> !busy)
    else $error("load beat made the block busy");

  // a query beat always starts work
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.operation == phpi_pkg::OP_QUERY) |=> busy)
    else $error("query beat not started");

endmodule
